@@ hdl/aarm_pkg.sv @@
// ============================================================================
// Axis-angle to rotation matrix package
// Shared widths, constants, data types and helper functions, most of them for elaboration.
// ============================================================================
package aarm_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 20;
	localparam int OUT_W      = 18;
	localparam int GB         = 30;
	localparam int MAX_STAGES = 32;
	localparam int SUM_W      = 40;
	localparam int NORM_W     = 30;
	localparam int SQ_W       = 2 * NORM_W;
	localparam int SQRT_STEPS = NORM_W;
	localparam int DIV_STEPS  = GB + 1;
	localparam int MOD_STEPS  = 5;
	localparam int TH_W       = 24;
	localparam int DW         = 34;
	localparam int DIV_PATH   = DIV_STEPS + 1;
	localparam int ANG_FIXED  = MOD_STEPS + 3;
	localparam int FRONT_LAT  = SQRT_STEPS + 2;
	localparam int POST_LAT   = 4;

	localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam logic [63:0] TWO_PI_F   =
		(TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
	localparam logic [63:0] PI_G       = (PI_Q60 + (64'd1 << 29)) >> 30;
	localparam logic [63:0] HALF_PI_G  = (PI_Q60 + (64'd1 << 30)) >> 31;
	localparam logic [63:0] LIMIT      =
		((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000000000;

	typedef struct packed {
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] r;
	} sqrt_t;

	typedef struct packed {
		logic [NORM_W-1:0]    rem;
		logic [DIV_STEPS-1:0] low;
		logic [DIV_STEPS-1:0] q;
		logic [NORM_W-1:0]    dv;
	} div_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic                 flip;
	} cordic_t;

	typedef struct packed {
		logic [2:0][IN_W-1:0] mag;
		logic [2:0]           neg;
		logic [IN_W-1:0]      aang;
		logic                 aneg;
	} side_t;

	// Shift-subtract division, used only for constants at elaboration.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem  = rem - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] vv;
		logic [63:0] r;
		logic [63:0] b;
		vv = v;
		r  = '0;
		b  = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (vv >= r + b) begin
				vv = vv - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0] s;
		logic [63:0] t;
		s = '0;
		if (i == 0) begin
			return (((PI_Q60 + 64'd2) >> 2) + (64'd1 << 29)) >> 30;
		end
		for (int k = 0; k < 31; k++) begin
			if (i * (2 * k + 1) <= 60) begin
				t = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
				if (k % 2 == 1) begin
					s = s - t;
				end else begin
					s = s + t;
				end
			end
		end
		return (s + (64'd1 << 29)) >> 30;
	endfunction

	function automatic logic [63:0] gain_inv(input int stages);
		logic [63:0] p;
		logic [63:0] a;
		p = 64'd1 << 60;
		for (int i = 0; i < MAX_STAGES; i++) begin
			if (i < stages) begin
				p = p + (p >> (2 * i));
			end
		end
		a = isqrt64(p);
		return udiv64((64'd1 << 60) + (a >> 1), a);
	endfunction

	function automatic int join_lat(input int stages);
		return (ANG_FIXED + stages > DIV_PATH) ? ANG_FIXED + stages : DIV_PATH;
	endfunction

	function automatic int total_lat(input int stages);
		return FRONT_LAT + join_lat(stages) + POST_LAT;
	endfunction

	localparam logic signed [2*DW-1:0] MQ_RND = (2*DW)'(1) <<< (GB - 1);

	// Fixed-point product rounded half up back to GB fraction bits.
	function automatic logic signed [DW-1:0] mq(input logic signed [DW-1:0] a,
	                                            input logic signed [DW-1:0] b);
		logic signed [2*DW-1:0] p;
		p = a * b;
		p = p + MQ_RND;
		p = p >>> GB;
		return p[DW-1:0];
	endfunction

endpackage

@@ hdl/aarm_delay.sv @@
// ============================================================================
// Aligning delay line
// Fixed-depth register line that keeps side data in step with a cell chain.
// ============================================================================
module aarm_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	generate
		if (DEPTH == 0) begin : g_pass
			assign q = d;
		end else begin : g_line
			logic [W-1:0] line_q [DEPTH];
			always_ff @(posedge clk) begin
				line_q[0] <= d;
				for (int i = 1; i < DEPTH; i++) begin
					line_q[i] <= line_q[i-1];
				end
			end
			assign q = line_q[DEPTH-1];
		end
	endgenerate
endmodule

@@ hdl/aarm_sqrt_cell.sv @@
// ============================================================================
// Square root cell
// One result bit of the digit-by-digit integer square root per cell.
// ============================================================================
module aarm_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  aarm_pkg::sqrt_t d,
	output aarm_pkg::sqrt_t q
);
	import aarm_pkg::*;

	localparam logic [SQ_W-1:0] B = SQ_W'(64'd1 << (2 * (SQRT_STEPS - 1 - STEP)));

	logic [SQ_W:0] trial;
	sqrt_t         nxt;

	always_comb begin
		trial = {1'b0, d.r} + {1'b0, B};
		if ({1'b0, d.v} >= trial) begin
			nxt.v = d.v - trial[SQ_W-1:0];
			nxt.r = (d.r >> 1) + B;
		end else begin
			nxt.v = d.v;
			nxt.r = d.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end
endmodule

@@ hdl/aarm_div_cell.sv @@
// ============================================================================
// Division cell
// One quotient bit of a restoring division per cell; the divisor rides along.
// ============================================================================
module aarm_div_cell (
	input  logic          clk,
	input  aarm_pkg::div_t d,
	output aarm_pkg::div_t q
);
	import aarm_pkg::*;

	logic [NORM_W:0] rem2;
	logic [NORM_W:0] diff;
	logic            ge;
	div_t            nxt;

	always_comb begin
		rem2      = {d.rem, d.low[DIV_STEPS-1]};
		diff      = rem2 - {1'b0, d.dv};
		ge        = (rem2 >= {1'b0, d.dv});
		nxt.rem   = ge ? diff[NORM_W-1:0] : rem2[NORM_W-1:0];
		nxt.low   = d.low << 1;
		nxt.q     = {d.q[DIV_STEPS-2:0], ge};
		nxt.dv    = d.dv;
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end
endmodule

@@ hdl/aarm_cordic_cell.sv @@
// ============================================================================
// CORDIC rotation cell
// One micro-rotation of the rotation-mode CORDIC per cell.
// ============================================================================
module aarm_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  aarm_pkg::cordic_t d,
	output aarm_pkg::cordic_t q
);
	import aarm_pkg::*;

	localparam logic signed [DW-1:0] AT = DW'(atan_entry(IDX));

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	cordic_t              nxt;

	always_comb begin
		dx       = d.y >>> IDX;
		dy       = d.x >>> IDX;
		nxt.flip = d.flip;
		if (!d.z[DW-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - AT;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + AT;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end
endmodule

@@ hdl/axis_angle_to_rotation_matrix_top.sv @@
// ============================================================================
// Axis-angle to rotation matrix, top level
// Rodrigues formula in fixed point: norm, unit axis, reduced angle, CORDIC.
// ============================================================================
// Path: the 31-cell division chain sets the latency from start to done up to 24
//   CORDIC stages, the CORDIC chain beyond that.
// Throughput: one beat per clock cycle; busy stays low, every cell advances
//   each cycle and the receiver takes each result in its done cycle.
// Reset: arst_n clears only the valid pipeline; data registers carry no reset.
module axis_angle_to_rotation_matrix_top #(
	parameter int CORDIC_STAGES = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [aarm_pkg::IN_W-1:0]  axis_x,
	input  logic signed [aarm_pkg::IN_W-1:0]  axis_y,
	input  logic signed [aarm_pkg::IN_W-1:0]  axis_z,
	input  logic signed [aarm_pkg::IN_W-1:0]  angle,
	output logic                              done,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_00,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_01,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_02,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_10,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_11,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_12,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_20,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_21,
	output logic signed [aarm_pkg::OUT_W-1:0] rot_22,
	output logic                              degenerate_axis
);
	import aarm_pkg::*;

	localparam int JOIN  = join_lat(CORDIC_STAGES);
	localparam int LAT   = total_lat(CORDIC_STAGES);
	localparam int U_DLY = JOIN - DIV_PATH;
	localparam int C_DLY = JOIN - ANG_FIXED - CORDIC_STAGES;
	localparam int SW    = DW + 2;
	localparam int SH    = GB - FRAC_BITS;

	localparam logic signed [DW-1:0]    KINV_S  = DW'(gain_inv(CORDIC_STAGES));
	localparam logic signed [DW-1:0]    PI_GS   = DW'(PI_G);
	localparam logic signed [DW-1:0]    HPI_GS  = DW'(HALF_PI_G);
	localparam logic signed [DW-1:0]    ONE_GB  = DW'(1) <<< GB;
	localparam logic [DIV_STEPS-1:0]    ONE_Q   = DIV_STEPS'(1) << GB;
	localparam logic [TH_W-1:0]         TPF     = TH_W'(TWO_PI_F);
	localparam logic signed [SW-1:0]    FIN_RND = SW'(1) <<< (SH - 1);
	localparam logic signed [SW-1:0]    ONE_S   = SW'(1) <<< FRAC_BITS;
	localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1) <<< FRAC_BITS;

	// The block never stalls its sender: a new beat may enter every cycle.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Valid pipeline. This is the only state that reset clears.
	// ------------------------------------------------------------------
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[LAT-1];

	// ------------------------------------------------------------------
	// Front end: squares and magnitudes, then the sum of squares and the
	// degenerate-axis test. The only degenerate case at this precision is
	// the zero axis, but the test follows the threshold constant.
	// ------------------------------------------------------------------
	logic signed [2*IN_W-1:0] px;
	logic signed [2*IN_W-1:0] py;
	logic signed [2*IN_W-1:0] pz;

	always_comb begin
		px = axis_x * axis_x;
		py = axis_y * axis_y;
		pz = axis_z * axis_z;
	end

	logic [SUM_W-2:0] sq_s1 [3];
	side_t            side_s1;

	always_ff @(posedge clk) begin
		sq_s1[0]        <= px[SUM_W-2:0];
		sq_s1[1]        <= py[SUM_W-2:0];
		sq_s1[2]        <= pz[SUM_W-2:0];
		side_s1.mag[0]  <= axis_x[IN_W-1] ? IN_W'(-axis_x) : axis_x;
		side_s1.mag[1]  <= axis_y[IN_W-1] ? IN_W'(-axis_y) : axis_y;
		side_s1.mag[2]  <= axis_z[IN_W-1] ? IN_W'(-axis_z) : axis_z;
		side_s1.neg     <= {axis_z[IN_W-1], axis_y[IN_W-1], axis_x[IN_W-1]};
		side_s1.aang    <= angle[IN_W-1] ? IN_W'(-angle) : angle;
		side_s1.aneg    <= angle[IN_W-1];
	end

	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-1:0] sum_s2;
	logic             degen_s2;
	side_t            side_s2;

	assign sum_c = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);

	always_ff @(posedge clk) begin
		sum_s2   <= sum_c;
		degen_s2 <= (64'(sum_c) <= LIMIT);
		side_s2  <= side_s1;
	end

	// ------------------------------------------------------------------
	// Square root chain: norm = floor(sqrt(sumsq * 2^20)), one bit per cell.
	// ------------------------------------------------------------------
	sqrt_t sq_c [SQRT_STEPS+1];

	assign sq_c[0].v = {sum_s2, (SQ_W - SUM_W)'(0)};
	assign sq_c[0].r = '0;

	generate
		for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
			aarm_sqrt_cell #(.STEP(k)) u_cell (
				.clk (clk),
				.d   (sq_c[k]),
				.q   (sq_c[k+1])
			);
		end
	endgenerate

	side_t side_p;

	aarm_delay #(.W($bits(side_t)), .DEPTH(SQRT_STEPS)) u_side_dly (
		.clk (clk),
		.d   (side_s2),
		.q   (side_p)
	);

	logic [NORM_W-1:0] n_p;
	assign n_p = sq_c[SQRT_STEPS].r[NORM_W-1:0];

	// ------------------------------------------------------------------
	// Unit axis: three division chains, round(|a| * 2^40 / norm), one
	// quotient bit per cell, then saturation to 1.0 and the sign.
	// ------------------------------------------------------------------
	logic [2:0]            q_neg_d;
	logic signed [DW-1:0]  usat_s3 [3];

	aarm_delay #(.W(3), .DEPTH(DIV_STEPS)) u_sign_dly (
		.clk (clk),
		.d   (side_p.neg),
		.q   (q_neg_d)
	);

	generate
		for (genvar l = 0; l < 3; l++) begin : g_lane
			div_t                  dv_c [DIV_STEPS+1];
			logic [2*NORM_W:0]     num;
			logic [DIV_STEPS-1:0]  qs;

			assign num = ((2*NORM_W+1)'(side_p.mag[l]) << (GB + 10)) +
			             (2*NORM_W+1)'(n_p >> 1);

			assign dv_c[0].rem = num[2*NORM_W -: NORM_W];
			assign dv_c[0].low = num[DIV_STEPS-1:0];
			assign dv_c[0].q   = '0;
			assign dv_c[0].dv  = n_p;

			for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
				aarm_div_cell u_cell (
					.clk (clk),
					.d   (dv_c[k]),
					.q   (dv_c[k+1])
				);
			end

			assign qs = (dv_c[DIV_STEPS].q > ONE_Q) ? ONE_Q : dv_c[DIV_STEPS].q;

			always_ff @(posedge clk) begin
				usat_s3[l] <= q_neg_d[l] ? -DW'(qs) : DW'(qs);
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// Effective angle: norm * |angle|, reduced modulo 2pi by a short chain
	// of compare-and-subtract steps, sign restored, centered, folded.
	// ------------------------------------------------------------------
	logic [NORM_W+IN_W-1:0] prod_s3;
	logic                   aneg_s3;
	logic [NORM_W+IN_W:0]   th_sum;
	logic [TH_W-1:0]        th_c;

	always_ff @(posedge clk) begin
		prod_s3 <= n_p * side_p.aang;
		aneg_s3 <= side_p.aneg;
	end

	assign th_sum = (NORM_W+IN_W+1)'(prod_s3) + ((NORM_W+IN_W+1)'(1) << (FRAC_BITS + 9));
	assign th_c   = TH_W'(th_sum >> (FRAC_BITS + 10));

	function automatic logic [TH_W-1:0] mod_step(input logic [TH_W-1:0] r, input int j);
		logic [TH_W-1:0] dd;
		dd = TH_W'(TWO_PI_F << (MOD_STEPS - 1 - j));
		return (r >= dd) ? r - dd : r;
	endfunction

	logic [TH_W-1:0] mod_r_s4 [MOD_STEPS];
	logic            mod_n_s4 [MOD_STEPS];

	always_ff @(posedge clk) begin
		mod_r_s4[0] <= mod_step(th_c, 0);
		mod_n_s4[0] <= aneg_s3;
		for (int j = 1; j < MOD_STEPS; j++) begin
			mod_r_s4[j] <= mod_step(mod_r_s4[j-1], j);
			mod_n_s4[j] <= mod_n_s4[j-1];
		end
	end

	logic [TH_W-1:0]      r1;
	logic signed [TH_W:0] zc_c;
	logic signed [TH_W:0] zc_s5;

	always_comb begin
		if (mod_n_s4[MOD_STEPS-1] && (mod_r_s4[MOD_STEPS-1] != '0)) begin
			r1 = TPF - mod_r_s4[MOD_STEPS-1];
		end else begin
			r1 = mod_r_s4[MOD_STEPS-1];
		end
		// Angles past pi come back as negative angles.
		if ({r1, 1'b0} > {1'b0, TPF}) begin
			zc_c = $signed({1'b0, r1}) - $signed({1'b0, TPF});
		end else begin
			zc_c = $signed({1'b0, r1});
		end
	end

	always_ff @(posedge clk) begin
		zc_s5 <= zc_c;
	end

	logic signed [DW-1:0] zw;
	logic signed [DW-1:0] z_c;
	logic                 flip_c;
	logic signed [DW-1:0] z_s6;
	logic                 flip_s6;

	always_comb begin
		zw     = DW'(zc_s5) <<< SH;
		z_c    = zw;
		flip_c = 1'b0;
		// Outside +-pi/2 the rotation is turned by pi; cos and sin flip sign.
		if (zw > HPI_GS) begin
			z_c    = zw - PI_GS;
			flip_c = 1'b1;
		end else if (zw < -HPI_GS) begin
			z_c    = zw + PI_GS;
			flip_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		z_s6    <= z_c;
		flip_s6 <= flip_c;
	end

	// ------------------------------------------------------------------
	// CORDIC chain, start vector (1/K, 0) with K the CORDIC gain.
	// ------------------------------------------------------------------
	cordic_t cc [CORDIC_STAGES+1];

	assign cc[0].x    = KINV_S;
	assign cc[0].y    = '0;
	assign cc[0].z    = z_s6;
	assign cc[0].flip = flip_s6;

	generate
		for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
			aarm_cordic_cell #(.IDX(k)) u_cell (
				.clk (clk),
				.d   (cc[k]),
				.q   (cc[k+1])
			);
		end
	endgenerate

	// ------------------------------------------------------------------
	// Join: the shorter of the two paths is delayed to meet the longer.
	// ------------------------------------------------------------------
	logic [3*DW-1:0]      u_jp;
	logic signed [DW-1:0] u_j [3];
	cordic_t              cj;

	aarm_delay #(.W(3*DW), .DEPTH(U_DLY)) u_u_dly (
		.clk (clk),
		.d   ({usat_s3[2], usat_s3[1], usat_s3[0]}),
		.q   (u_jp)
	);

	assign u_j[0] = u_jp[DW-1:0];
	assign u_j[1] = u_jp[2*DW-1:DW];
	assign u_j[2] = u_jp[3*DW-1:2*DW];

	aarm_delay #(.W($bits(cordic_t)), .DEPTH(C_DLY)) u_c_dly (
		.clk (clk),
		.d   (cc[CORDIC_STAGES]),
		.q   (cj)
	);

	logic [0:0] degen_d;

	aarm_delay #(.W(1), .DEPTH(SQRT_STEPS + JOIN + 3)) u_degen_dly (
		.clk (clk),
		.d   (degen_s2),
		.q   (degen_d)
	);

	// ------------------------------------------------------------------
	// Matrix: products u_i u_j, then scaling by (1 - cos), sin terms, sums.
	// Product order: xx, yy, zz, xy, xz, yz.
	// ------------------------------------------------------------------
	logic signed [DW-1:0] c_s7;
	logic signed [DW-1:0] s_s7;
	logic signed [DW-1:0] lc_s7;
	logic signed [DW-1:0] uu_s7 [6];
	logic signed [DW-1:0] u_s7 [3];
	logic signed [DW-1:0] c_j;

	assign c_j = cj.flip ? -cj.x : cj.x;

	always_ff @(posedge clk) begin
		c_s7     <= c_j;
		s_s7     <= cj.flip ? -cj.y : cj.y;
		lc_s7    <= ONE_GB - c_j;
		uu_s7[0] <= mq(u_j[0], u_j[0]);
		uu_s7[1] <= mq(u_j[1], u_j[1]);
		uu_s7[2] <= mq(u_j[2], u_j[2]);
		uu_s7[3] <= mq(u_j[0], u_j[1]);
		uu_s7[4] <= mq(u_j[0], u_j[2]);
		uu_s7[5] <= mq(u_j[1], u_j[2]);
		for (int i = 0; i < 3; i++) begin
			u_s7[i] <= u_j[i];
		end
	end

	logic signed [DW-1:0] c_s8;
	logic signed [DW-1:0] ul_s8 [6];
	logic signed [DW-1:0] us_s8 [3];

	always_ff @(posedge clk) begin
		c_s8 <= c_s7;
		for (int i = 0; i < 6; i++) begin
			ul_s8[i] <= mq(uu_s7[i], lc_s7);
		end
		for (int i = 0; i < 3; i++) begin
			us_s8[i] <= mq(u_s7[i], s_s7);
		end
	end

	logic signed [SW-1:0] e_s9 [9];

	always_ff @(posedge clk) begin
		e_s9[0] <= SW'(c_s8) + SW'(ul_s8[0]);
		e_s9[1] <= SW'(ul_s8[3]) - SW'(us_s8[2]);
		e_s9[2] <= SW'(us_s8[1]) + SW'(ul_s8[4]);
		e_s9[3] <= SW'(us_s8[2]) + SW'(ul_s8[3]);
		e_s9[4] <= SW'(c_s8) + SW'(ul_s8[1]);
		e_s9[5] <= SW'(ul_s8[5]) - SW'(us_s8[0]);
		e_s9[6] <= SW'(ul_s8[4]) - SW'(us_s8[1]);
		e_s9[7] <= SW'(us_s8[0]) + SW'(ul_s8[5]);
		e_s9[8] <= SW'(c_s8) + SW'(ul_s8[2]);
	end

	// Round half up to the output fraction and clamp to +-1.
	function automatic logic [OUT_W-1:0] finish(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		t = (v + FIN_RND) >>> SH;
		if (t > ONE_S) begin
			t = ONE_S;
		end else if (t < -ONE_S) begin
			t = -ONE_S;
		end
		return t[OUT_W-1:0];
	endfunction

	logic signed [OUT_W-1:0] rot_s10 [9];
	logic                    degen_s10;

	always_ff @(posedge clk) begin
		degen_s10 <= degen_d[0];
		for (int i = 0; i < 9; i++) begin
			if (degen_d[0]) begin
				// Degenerate axis: the identity matrix.
				rot_s10[i] <= (i % 4 == 0) ? ONE_OUT : '0;
			end else begin
				rot_s10[i] <= finish(e_s9[i]);
			end
		end
	end

	assign rot_00          = rot_s10[0];
	assign rot_01          = rot_s10[1];
	assign rot_02          = rot_s10[2];
	assign rot_10          = rot_s10[3];
	assign rot_11          = rot_s10[4];
	assign rot_12          = rot_s10[5];
	assign rot_20          = rot_s10[6];
	assign rot_21          = rot_s10[7];
	assign rot_22          = rot_s10[8];
	assign degenerate_axis = degen_s10;

endmodule

@@ hdl/aarm_checker.sv @@
// ============================================================================
// Axis-angle to rotation matrix checker
// Port-level assertions on latency, output range and the identity case.
// ============================================================================
module aarm_checker #(
	parameter int CORDIC_STAGES = 18
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_00,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_01,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_02,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_10,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_11,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_12,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_20,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_21,
	input logic signed [aarm_pkg::OUT_W-1:0] rot_22,
	input logic                              degenerate_axis
);
	import aarm_pkg::*;

	localparam int LAT = total_lat(CORDIC_STAGES);
	localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) <<< FRAC_BITS;

	function automatic logic in_rng(input logic signed [OUT_W-1:0] v);
		return (v <= ONE) && (v >= -ONE);
	endfunction

	a_lat_fwd : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat did not produce a result on time");

	a_lat_back : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching accepted beat");

	a_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (in_rng(rot_00) && in_rng(rot_01) && in_rng(rot_02) &&
		          in_rng(rot_10) && in_rng(rot_11) && in_rng(rot_12) &&
		          in_rng(rot_20) && in_rng(rot_21) && in_rng(rot_22)))
		else $error("matrix entry outside +-1");

	a_ident : assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate_axis) |->
			(rot_00 == ONE && rot_11 == ONE && rot_22 == ONE &&
			 rot_01 == '0 && rot_02 == '0 && rot_10 == '0 &&
			 rot_12 == '0 && rot_20 == '0 && rot_21 == '0))
		else $error("degenerate axis without identity matrix");

endmodule

bind axis_angle_to_rotation_matrix_top aarm_checker #(
	.CORDIC_STAGES(CORDIC_STAGES)
) u_aarm_checker (.*);

@@ tb/sv/rodrigues_checker.sv @@
// ============================================================================
// Rodrigues rotation matrix checker
// Watches the start and done channels and predicts each matrix from the axis
// and angle. Results come back in order and are compared field by field.
// ============================================================================
module rodrigues_checker #(
	parameter int CORDIC_STAGES = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic signed [aarm_pkg::IN_W-1:0]  axis_x,
	input  logic signed [aarm_pkg::IN_W-1:0]  axis_y,
	input  logic signed [aarm_pkg::IN_W-1:0]  axis_z,
	input  logic signed [aarm_pkg::IN_W-1:0]  angle,
	input  logic                              done,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_00,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_01,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_02,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_10,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_11,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_12,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_20,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_21,
	input  logic signed [aarm_pkg::OUT_W-1:0] rot_22,
	input  logic                              degenerate_axis,
	output int                                fail_count,
	output int                                pending_matrices,
	output int                                matrices_checked,
	output int                                degenerate_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import aarm_pkg::*;

	localparam int FB   = 16;
	localparam int QB   = 30;
	localparam int OW   = 18;
	localparam longint unsigned DEG_LIMIT = ((64'd1 << (2 * FB)) - 64'd1) / 64'd1000000000000;

	typedef struct {
		logic signed [OW-1:0] m[9];
		logic                 deg;
	} matrix_t;

	matrix_t expected_matrices[$];
	string   entry_name[9] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11",
		"rot_12", "rot_20", "rot_21", "rot_22"};

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Arctangent of 2^-i at 30 fraction bits, by its power series at 60 bits.
	function automatic longint arctan_step(input int i);
		longint unsigned s;
		longint unsigned t;
		s = 0;
		if (i == 0) return longint'((((PI_Q60 + 64'd2) >> 2) + (64'd1 << 29)) >> 30);
		for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
			t = (64'd1 << (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
			if (k % 2 == 1) s = s - t;
			else s = s + t;
		end
		return longint'((s + (64'd1 << 29)) >> 30);
	endfunction

	function automatic longint inv_gain(input int stages);
		longint unsigned p;
		longint unsigned a;
		p = 64'd1 << 60;
		for (int i = 0; i < stages; i++) p = p + (p >> (2 * i));
		a = int_sqrt(p);
		return longint'(((64'd1 << 60) + a / 2) / a);
	endfunction

	function automatic longint unit_part(input longint a, input longint unsigned n);
		longint unsigned mag;
		longint unsigned q;
		mag = (a < 0) ? longint'(-a) : longint'(a);
		q = ((mag << (QB + 10)) + n / 2) / n;
		if (q > (64'd1 << QB)) q = 64'd1 << QB;
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b + (longint'(1) << (QB - 1))) >>> QB;
	endfunction

	function automatic logic signed [OW-1:0] to_entry(input longint v);
		longint one;
		one = longint'(1) << FB;
		v = (v + (longint'(1) << (QB - FB - 1))) >>> (QB - FB);
		if (v > one) v = one;
		if (v < -one) v = -one;
		return v[OW-1:0];
	endfunction

	function automatic matrix_t rotation_of(input logic signed [IN_W-1:0] ax_in,
		input logic signed [IN_W-1:0] ay_in, input logic signed [IN_W-1:0] az_in,
		input logic signed [IN_W-1:0] ang_in);
		matrix_t         res;
		longint          ax, ay, az, ang, z, x, y, dx, dy, c, s, lc, ux, uy, uz;
		longint          pi_g, half_pi_g, uxy, uxz, uyz, sx, sy, sz;
		longint unsigned sumsq, n, aang, th, two_pi_f, r;
		bit              flip;
		ax = ax_in;
		ay = ay_in;
		az = az_in;
		ang = ang_in;
		sumsq = ax * ax + ay * ay + az * az;
		res.deg = 1'b0;
		if (sumsq <= DEG_LIMIT) begin
			// A null axis gives the identity and raises the flag.
			foreach (res.m[i]) res.m[i] = (i % 4 == 0) ? to_entry(longint'(1) << QB) : '0;
			res.deg = 1'b1;
			return res;
		end
		n = int_sqrt(sumsq << 20);
		if (n == 0) n = 1;
		ux = unit_part(ax, n);
		uy = unit_part(ay, n);
		uz = unit_part(az, n);

		aang = (ang < 0) ? longint'(-ang) : longint'(ang);
		th = (n * aang + (64'd1 << (FB + 9))) >> (FB + 10);
		two_pi_f = (TWO_PI_Q60 + (64'd1 << (59 - FB))) >> (60 - FB);
		r = th % two_pi_f;
		if (ang < 0 && r != 0) r = two_pi_f - r;
		z = longint'(r);
		if (2 * r > two_pi_f) z = z - longint'(two_pi_f);
		z = z * (longint'(1) << (QB - FB));

		pi_g = longint'((PI_Q60 + (64'd1 << 29)) >> 30);
		half_pi_g = longint'((PI_Q60 + (64'd1 << 30)) >> 31);
		flip = 1'b0;
		if (z > half_pi_g) begin
			z = z - pi_g;
			flip = 1'b1;
		end else if (z < -half_pi_g) begin
			z = z + pi_g;
			flip = 1'b1;
		end

		x = inv_gain(CORDIC_STAGES);
		y = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_step(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_step(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		lc = (longint'(1) << QB) - c;

		uxy = qmul(qmul(ux, uy), lc);
		uxz = qmul(qmul(ux, uz), lc);
		uyz = qmul(qmul(uy, uz), lc);
		sx = qmul(ux, s);
		sy = qmul(uy, s);
		sz = qmul(uz, s);
		res.m[0] = to_entry(c + qmul(qmul(ux, ux), lc));
		res.m[1] = to_entry(uxy - sz);
		res.m[2] = to_entry(sy + uxz);
		res.m[3] = to_entry(sz + uxy);
		res.m[4] = to_entry(c + qmul(qmul(uy, uy), lc));
		res.m[5] = to_entry(uyz - sx);
		res.m[6] = to_entry(uxz - sy);
		res.m[7] = to_entry(sx + uyz);
		res.m[8] = to_entry(c + qmul(qmul(uz, uz), lc));
		return res;
	endfunction

	initial begin
		fail_count = 0;
		matrices_checked = 0;
		degenerate_checked = 0;
	end

	assign pending_matrices = expected_matrices.size();

	always @(posedge clk) begin
		matrix_t                want;
		logic signed [OW-1:0] got[9];
		if (arst_n) begin
			if (start && !busy)
				expected_matrices.insert(expected_matrices.size(),
					rotation_of(axis_x, axis_y, axis_z, angle));
			if (done) begin
				got = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
				if (expected_matrices.size() == 0) begin
					$error("matrix beat with no input waiting");
					fail_count++;
				end else begin
					want = expected_matrices.pop_front();
					foreach (got[i]) begin
						if (got[i] !== want.m[i]) begin
							$error("%s: expected %0d, got %0d", entry_name[i], want.m[i], got[i]);
							fail_count++;
						end
					end
					if (degenerate_axis !== want.deg) begin
						$error("degenerate_axis: expected %0d, got %0d", want.deg, degenerate_axis);
						fail_count++;
					end
					matrices_checked++;
					if (want.deg) degenerate_checked++;
				end
			end
		end
	end

endmodule

@@ tb/sv/tb_axis_angle_to_rotation_matrix_top.sv @@
// ============================================================================
// Axis-angle to rotation matrix testbench
// Drives axis and angle beats through directed corners and three random
// phases of sender idling; a checker beside the block predicts and compares.
// ============================================================================
module tb_axis_angle_to_rotation_matrix_top;
	timeunit 1ns;
	timeprecision 1ps;

	import aarm_pkg::*;

	localparam int STAGES = 18;
	// The drain wait is longer than the latency at the default stage count.
	localparam int DRAIN_CYCLES = 140;
	localparam int PHASE_ITEMS = 300;

	localparam logic signed [IN_W-1:0] FIELD_MIN = -20'sd524288;
	localparam logic signed [IN_W-1:0] FIELD_MAX = 20'sd524287;
	localparam logic signed [IN_W-1:0] ONE_Q16 = 20'sd65536;
	localparam logic signed [IN_W-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [IN_W-1:0] PI_Q16 = 20'sd205887;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [IN_W-1:0] axis_x, axis_y, axis_z, angle;
	logic done;
	logic signed [OUT_W-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
	logic signed [OUT_W-1:0] rot_20, rot_21, rot_22;
	logic degenerate_axis;
	int fail_count, pending_matrices, matrices_checked, degenerate_checked;
	int sender_idle_pct;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	axis_angle_to_rotation_matrix_top #(.CORDIC_STAGES(STAGES)) u_dut (.*);

	rodrigues_checker #(.CORDIC_STAGES(STAGES)) u_checker (.*);

	// Puts one beat on the command port and holds it until it is taken. Busy
	// only moves at a rising edge, so it is read at the falling edge before.
	task automatic send_rotation(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
		input logic signed [IN_W-1:0] z, input logic signed [IN_W-1:0] a);
		bit taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		angle <= a;
		forever begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
			if (taken) break;
		end
	endtask

	// Draws one axis component: mostly full range, sometimes small, zero or extreme,
	// so that both short axes and saturating unit components are reached.
	function automatic logic signed [IN_W-1:0] pick_component();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? FIELD_MIN : FIELD_MAX;
			1, 2: return IN_W'($signed($urandom_range(64)) - 32);
			3: return '0;
			default: return IN_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [IN_W-1:0] pick_angle();
		case ($urandom_range(7))
			0: return $urandom_range(1) ? FIELD_MIN : FIELD_MAX;
			1: return $urandom_range(1) ? HALF_PI_Q16 : -PI_Q16;
			2: return IN_W'($signed($urandom_range(8192)) - 4096);
			default: return IN_W'($urandom());
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		axis_x = '0;
		axis_y = '0;
		axis_z = '0;
		angle = '0;
		sender_idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: the null axis gives the identity with the flag set,
		// whatever the angle; unit axes at quarter and half turns; extreme
		// components and angles that exercise the wrap modulo two pi and the
		// saturation of entries that round past one.
		send_rotation('0, '0, '0, '0);
		send_rotation('0, '0, '0, FIELD_MAX);
		send_rotation('0, '0, '0, FIELD_MIN);
		send_rotation(ONE_Q16, '0, '0, HALF_PI_Q16);
		send_rotation('0, ONE_Q16, '0, HALF_PI_Q16);
		send_rotation('0, '0, ONE_Q16, -HALF_PI_Q16);
		send_rotation(ONE_Q16, '0, '0, PI_Q16);
		send_rotation('0, '0, -ONE_Q16, -PI_Q16);
		send_rotation(ONE_Q16, ONE_Q16, ONE_Q16, '0);
		send_rotation(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
		send_rotation(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN);
		send_rotation(FIELD_MIN, FIELD_MAX, '0, FIELD_MAX);
		send_rotation(20'sd1, '0, '0, FIELD_MAX);
		send_rotation('0, '0, -20'sd1, FIELD_MIN);
		send_rotation(20'sd1, -20'sd1, 20'sd1, 20'sd1);
		send_rotation(FIELD_MAX, '0, '0, 20'sd1);
		send_rotation('0, FIELD_MIN, '0, -20'sd1);
		send_rotation(ONE_Q16, -ONE_Q16, ONE_Q16, 20'sd137258);
		send_rotation(-20'sd40000, 20'sd12345, 20'sd99999, -20'sd300000);
		send_rotation(20'sd3, 20'sd4, '0, 20'sd51472);

		// Random beats in three phases: sparse gaps, heavy gaps, then none.
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 82 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_rotation(pick_component(), pick_component(), pick_component(), pick_angle());
		end
		start <= 1'b0;

		while (pending_matrices != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d rotation matrices, %0d of them for a null axis,",
			matrices_checked, degenerate_checked);
		$display("over directed corners and random beats with light, heavy and no sender gaps.");
		if (fail_count == 0 && pending_matrices == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Guard against a hung handshake or a missing result.
	initial begin
		#5ms;
		$display("Timed out with %0d matrices outstanding.", pending_matrices);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
